@@ rtl/core/pwbd_pkg.sv @@
// Shared types and constants for the pulse-width biphase decoder.
package pwbd_pkg;

  localparam int FRAME_BITS  = 34;
  localparam int CNT_W       = 7;
  localparam int WORD_W      = 32;
  localparam int WIDTH_W     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0]  COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_INIT  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  COUNT_FRAME = CNT_W'(FRAME_BITS);
  localparam logic [WORD_W-1:0] WORD_INIT   = WORD_W'(1);

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_START_MIN  = 3'd0,
    REG_START_MAX  = 3'd1,
    REG_TWO_MIN    = 3'd2,
    REG_TWO_MAX    = 3'd3,
    REG_THREE_MIN  = 3'd4,
    REG_THREE_MAX  = 3'd5,
    REG_FOUR_MIN   = 3'd6,
    REG_FOUR_MAX   = 3'd7
  } reg_idx_t;

  // Width class of one interval
  typedef enum logic [1:0] {
    UNITS_NONE  = 2'd0,
    UNITS_TWO   = 2'd1,
    UNITS_THREE = 2'd2,
    UNITS_FOUR  = 2'd3
  } units_t;

  // Timing bounds handed to the classifier
  typedef struct packed {
    logic [WIDTH_W-1:0] start_min;
    logic [WIDTH_W-1:0] start_max;
    logic [WIDTH_W-1:0] two_min;
    logic [WIDTH_W-1:0] two_max;
    logic [WIDTH_W-1:0] three_min;
    logic [WIDTH_W-1:0] three_max;
    logic [WIDTH_W-1:0] four_min;
    logic [WIDTH_W-1:0] four_max;
  } bounds_t;

  // Classified interval travelling through the queue
  typedef struct packed {
    logic   start_ok;
    units_t units;
  } item_t;

endpackage

@@ rtl/core/pulse_width_biphase_decoder.sv @@
// Pulse-width biphase decoder: an interval is registered in the classifier stage, the queue, then the result register.
// Throughput one interval per cycle when in_stall and out_stall allow: classifier stage, 2-entry queue, frame engine.
// Each accepted interval yields exactly one result transaction.
// Synchronous active-low reset: idle, no frame, last code 0, bounds to defaults.
// No clearing pass after reset; items are accepted in the first cycle after it.
module pulse_width_biphase_decoder
  import pwbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WIDTH_W-1:0] in_pulse_width,
  input  logic               in_line_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_code_valid,
  output logic [WORD_W-1:0]  out_code_word,
  output logic               out_falling_only,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  bounds_t bounds;
  logic    push, q_full, pop, q_not_empty;
  item_t   push_item, q_head;

  // Configuration
  pwbd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .bounds      (bounds)
  );

  // Classifier
  pwbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .bounds         (bounds),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pulse_width (in_pulse_width),
    .in_line_level  (in_line_level),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  // Decoupling queue
  pwbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Frame engine
  pwbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_valid   (out_code_valid),
    .out_code_word    (out_code_word),
    .out_falling_only (out_falling_only)
  );

endmodule

@@ rtl/core/pwbd_regs.sv @@
// APB-style configuration registers holding the interval bounds.
module pwbd_regs
  import pwbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output bounds_t           bounds
);

  logic [WIDTH_W-1:0] regs_r [8];
  reg_idx_t           idx;
  logic               wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Register file with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_START_MIN] <= WIDTH_W'(1300);
      regs_r[REG_START_MAX] <= WIDTH_W'(1700);
      regs_r[REG_TWO_MIN]   <= WIDTH_W'(1800);
      regs_r[REG_TWO_MAX]   <= WIDTH_W'(2200);
      regs_r[REG_THREE_MIN] <= WIDTH_W'(2800);
      regs_r[REG_THREE_MAX] <= WIDTH_W'(3200);
      regs_r[REG_FOUR_MIN]  <= WIDTH_W'(3800);
      regs_r[REG_FOUR_MAX]  <= WIDTH_W'(4200);
    end else if (wr_en) begin
      regs_r[idx] <= cfg_pwdata[WIDTH_W-1:0];
    end
  end

  // Read-back
  assign cfg_prdata = {{(DATA_W-WIDTH_W){1'b0}}, regs_r[idx]};

  assign bounds.start_min = regs_r[REG_START_MIN];
  assign bounds.start_max = regs_r[REG_START_MAX];
  assign bounds.two_min   = regs_r[REG_TWO_MIN];
  assign bounds.two_max   = regs_r[REG_TWO_MAX];
  assign bounds.three_min = regs_r[REG_THREE_MIN];
  assign bounds.three_max = regs_r[REG_THREE_MAX];
  assign bounds.four_min  = regs_r[REG_FOUR_MIN];
  assign bounds.four_max  = regs_r[REG_FOUR_MAX];

endmodule

@@ rtl/core/pwbd_front.sv @@
// Front end: accepts intervals and sorts them into width classes.
module pwbd_front
  import pwbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bounds_t            bounds,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WIDTH_W-1:0] in_pulse_width,
  input  logic               in_line_level,
  output logic               push,
  output item_t              push_item,
  input  logic               q_full
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  // Hold while the staged item cannot enter the queue
  assign in_stall  = valid_r & q_full;
  assign push      = valid_r & ~q_full;
  assign push_item = item_r;
  assign take      = in_valid & ~in_stall;

  // Classification
  always_comb begin
    item_nxt.start_ok = (in_pulse_width > bounds.start_min) &&
                        (in_pulse_width < bounds.start_max) && !in_line_level;
    priority if (in_pulse_width >= bounds.two_min && in_pulse_width <= bounds.two_max)
      item_nxt.units = UNITS_TWO;
    else if (in_pulse_width >= bounds.three_min && in_pulse_width <= bounds.three_max)
      item_nxt.units = UNITS_THREE;
    else if (in_pulse_width >= bounds.four_min && in_pulse_width <= bounds.four_max)
      item_nxt.units = UNITS_FOUR;
    else
      item_nxt.units = UNITS_NONE;
  end

  assign valid_nxt = take | (valid_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/pwbd_queue.sv @@
// Short FIFO between classifier and frame engine.
module pwbd_queue
  import pwbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/pwbd_back.sv @@
// Frame engine: shifts in decoded bits and holds the result register.
module pwbd_back
  import pwbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  item_t             q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_code_valid,
  output logic [WORD_W-1:0] out_code_word,
  output logic              out_falling_only
);

  logic              out_valid_r, out_valid_nxt;
  logic              code_valid_r, code_valid_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] last_code_r, last_code_nxt;

  logic              prev_bit;
  logic [WORD_W-1:0] sh1, sh1_or, sh2;
  logic [CNT_W-1:0]  c1, c2;
  logic              abort;

  // A new transaction moves in once the result slot is free
  assign pop = q_not_empty & (~out_valid_r | ~out_stall);

  assign prev_bit = shift_r[0];
  assign sh1      = {shift_r[WORD_W-2:0], 1'b0};
  assign sh1_or   = {shift_r[WORD_W-2:0], 1'b1};
  assign sh2      = {sh1_or[WORD_W-2:0], 1'b0};
  assign c1       = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 1'b1;
  assign c2       = (c1 == COUNT_MAX) ? COUNT_MAX : c1 + 1'b1;

  // Bit decoding and frame sequencing
  always_comb begin
    shift_nxt      = shift_r;
    count_nxt      = count_r;
    in_frame_nxt   = in_frame_r;
    last_code_nxt  = last_code_r;
    code_valid_nxt = code_valid_r;
    out_valid_nxt  = out_valid_r & out_stall;
    abort          = 1'b0;
    if (pop) begin
      out_valid_nxt  = 1'b1;
      code_valid_nxt = 1'b0;
      if (!in_frame_r) begin
        in_frame_nxt = q_head.start_ok;
      end else begin
        unique case (q_head.units)
          UNITS_TWO: begin
            shift_nxt = {shift_r[WORD_W-2:0], prev_bit};
            count_nxt = c1;
          end
          UNITS_THREE: begin
            shift_nxt = prev_bit ? sh2 : sh1_or;
            count_nxt = prev_bit ? c2 : c1;
          end
          UNITS_FOUR: begin
            shift_nxt = prev_bit ? sh1 : sh2;
            count_nxt = prev_bit ? c1 : c2;
            abort     = prev_bit;
          end
          UNITS_NONE: begin
            shift_nxt = sh1;
            count_nxt = c1;
            abort     = 1'b1;
          end
        endcase
        in_frame_nxt = ~abort;
        // Frame complete, still emitted if this step aborted
        if (count_nxt == COUNT_FRAME) begin
          last_code_nxt  = shift_nxt;
          code_valid_nxt = 1'b1;
          in_frame_nxt   = 1'b0;
        end
      end
      if (!in_frame_nxt) begin
        shift_nxt = WORD_INIT;
        count_nxt = COUNT_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      code_valid_r <= 1'b0;
      in_frame_r   <= 1'b0;
      shift_r      <= WORD_INIT;
      count_r      <= COUNT_INIT;
      last_code_r  <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      code_valid_r <= code_valid_nxt;
      in_frame_r   <= in_frame_nxt;
      shift_r      <= shift_nxt;
      count_r      <= count_nxt;
      last_code_r  <= last_code_nxt;
    end
  end

  // State only moves on a pop, so it doubles as the result register
  assign out_valid        = out_valid_r;
  assign out_code_valid   = code_valid_r;
  assign out_code_word    = last_code_r;
  assign out_falling_only = in_frame_r;

endmodule

@@ tb/sv/pulse_width_biphase_decoder_test.sv @@
// Self-checking testbench for the pulse-width biphase decoder: stimulus, bounds, code checks.
module pulse_width_biphase_decoder_test
  import pwbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_LATENCY = 3;
  localparam int MIX_TARGET   = 1150;

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic              code_valid;
    logic [WORD_W-1:0] code_word;
    logic              falling_only;
  } code_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WIDTH_W-1:0] in_pulse_width = '0;
  logic               in_line_level = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_code_valid;
  logic [WORD_W-1:0]  out_code_word;
  logic               out_falling_only;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]  cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Decoder state as the testbench tracks it
  bounds_t            bounds_now;
  logic               frame_open = 1'b0;
  logic [WORD_W-1:0]  shift_bits = WORD_INIT;
  logic [CNT_W-1:0]   bits_seen = COUNT_INIT;
  logic [WORD_W-1:0]  held_code = '0;

  code_result_t       expected_codes[$];
  int                 items_sent = 0;
  int                 fail_count = 0;

  // Idle control: idle_enable is shared by sender and receiver, the rest is the receiver's
  bit                 idle_enable = 1'b1;
  int                 hold_left = 0;
  int                 stall_run = 0;
  int                 free_run = 0;

  pulse_width_biphase_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pulse_width   (in_pulse_width),
    .in_line_level    (in_line_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_valid   (out_code_valid),
    .out_code_word    (out_code_word),
    .out_falling_only (out_falling_only),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bounds_t default_bounds();
    bounds_t b;
    b.start_min = 16'd1300;
    b.start_max = 16'd1700;
    b.two_min   = 16'd1800;
    b.two_max   = 16'd2200;
    b.three_min = 16'd2800;
    b.three_max = 16'd3200;
    b.four_min  = 16'd3800;
    b.four_max  = 16'd4200;
    return b;
  endfunction

  // Bounds scaled to one unit of u ticks, roughly 10 % tolerance
  function automatic bounds_t scaled_bounds(int u);
    bounds_t b;
    int d;
    d = u / 10 + 1;
    b.start_min = 16'(u * 13 / 10);
    b.start_max = 16'(u * 17 / 10);
    b.two_min   = 16'(2 * u - d);
    b.two_max   = 16'(2 * u + d);
    b.three_min = 16'(3 * u - d);
    b.three_max = 16'(3 * u + d);
    b.four_min  = 16'(4 * u - d);
    b.four_max  = 16'(4 * u + d);
    return b;
  endfunction

  // Two-unit class wins, then three, then four
  function automatic units_t classify(logic [WIDTH_W-1:0] w);
    if (w >= bounds_now.two_min && w <= bounds_now.two_max) return UNITS_TWO;
    if (w >= bounds_now.three_min && w <= bounds_now.three_max) return UNITS_THREE;
    if (w >= bounds_now.four_min && w <= bounds_now.four_max) return UNITS_FOUR;
    return UNITS_NONE;
  endfunction

  function automatic logic [CNT_W-1:0] count_sat(logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Advance the tracked decoder by one interval and return the expected result
  function automatic code_result_t step_decoder(logic [WIDTH_W-1:0] w, logic lvl);
    code_result_t r;
    logic last;
    r.code_valid = 1'b0;
    if (!frame_open) begin
      if (w > bounds_now.start_min && w < bounds_now.start_max && !lvl) begin
        frame_open = 1'b1;
        bits_seen  = COUNT_INIT;
        shift_bits = WORD_INIT;
      end
    end else begin
      last       = shift_bits[0];
      shift_bits = shift_bits << 1;
      bits_seen  = count_sat(bits_seen);
      case (classify(w))
        UNITS_TWO: begin
          shift_bits[0] = last;
        end
        UNITS_THREE: begin
          shift_bits[0] = 1'b1;
          if (last) begin
            shift_bits = shift_bits << 1;
            bits_seen  = count_sat(bits_seen);
          end
        end
        UNITS_FOUR: begin
          // four units only follow a 0
          if (!last) begin
            shift_bits[0] = 1'b1;
            shift_bits    = shift_bits << 1;
            bits_seen     = count_sat(bits_seen);
          end else begin
            frame_open = 1'b0;
          end
        end
        default: begin
          frame_open = 1'b0;
        end
      endcase
      // emit on the exact count, even when this step aborted
      if (bits_seen == COUNT_FRAME) begin
        held_code    = shift_bits;
        r.code_valid = 1'b1;
        frame_open   = 1'b0;
      end
    end
    if (!frame_open) begin
      bits_seen  = COUNT_INIT;
      shift_bits = WORD_INIT;
    end
    r.code_word    = held_code;
    r.falling_only = frame_open;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WIDTH_W-1:0] start_width();
    if (bounds_now.start_max > bounds_now.start_min + 1)
      return 16'($urandom_range(bounds_now.start_min + 1, bounds_now.start_max - 1));
    return 16'($urandom);
  endfunction

  // A width that falls in no class, often right beside a bound
  function automatic logic [WIDTH_W-1:0] abort_width();
    logic [WIDTH_W-1:0] w;
    w = 16'($urandom);
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 7))
        0: w = bounds_now.two_min - 1'b1;
        1: w = bounds_now.two_max + 1'b1;
        2: w = bounds_now.three_min - 1'b1;
        3: w = bounds_now.three_max + 1'b1;
        4: w = bounds_now.four_min - 1'b1;
        5: w = bounds_now.four_max + 1'b1;
        default: w = 16'($urandom);
      endcase
      if (classify(w) == UNITS_NONE) return w;
    end
    return w;
  endfunction

  function automatic logic [WIDTH_W-1:0] unit_width(units_t u);
    logic [WIDTH_W-1:0] lo;
    logic [WIDTH_W-1:0] hi;
    int r;
    case (u)
      UNITS_TWO: begin
        lo = bounds_now.two_min;
        hi = bounds_now.two_max;
      end
      UNITS_THREE: begin
        lo = bounds_now.three_min;
        hi = bounds_now.three_max;
      end
      UNITS_FOUR: begin
        lo = bounds_now.four_min;
        hi = bounds_now.four_max;
      end
      default: return abort_width();
    endcase
    if (lo > hi) return 16'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 16'($urandom_range(lo, hi));
  endfunction

  // Legal class for the next interval; avoids jumping past stop_at unless allowed
  function automatic units_t pick_class(bit may_skip, int stop_at);
    units_t u;
    bit two_step;
    if (shift_bits[0]) begin
      u = ($urandom_range(0, 1) == 0) ? UNITS_TWO : UNITS_THREE;
      two_step = (u == UNITS_THREE);
    end else begin
      case ($urandom_range(0, 2))
        0: u = UNITS_TWO;
        1: u = UNITS_THREE;
        default: u = UNITS_FOUR;
      endcase
      two_step = (u == UNITS_FOUR);
    end
    if (!may_skip && two_step && stop_at - int'(bits_seen) == 1) u = UNITS_TWO;
    return u;
  endfunction

  // Offer one interval, wait for its acceptance and record what it should give
  task automatic send_interval(logic [WIDTH_W-1:0] w, logic lvl);
    int gap;
    gap = idle_enable ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pulse_width <= w;
    in_line_level  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_codes.push_back(step_decoder(w, lvl));
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop offering until every code is back, then let the pipeline settle
  task automatic wait_for_codes();
    release_input();
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (CODE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic continue_frame(int stop_at, bit may_skip);
    int steps;
    steps = 0;
    while (frame_open && int'(bits_seen) < stop_at && steps < 200) begin
      send_interval(unit_width(pick_class(may_skip, stop_at)), 1'($urandom));
      steps++;
    end
  endtask

  task automatic send_frame(int stop_at, bit may_skip);
    send_interval(start_width(), 1'b0);
    continue_frame(stop_at, may_skip);
  endtask

  // Register write: setup then access phase
  task automatic write_bound(reg_idx_t idx, logic [WIDTH_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= {16'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    bounds_now[(7 - int'(idx)) * WIDTH_W +: WIDTH_W] = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_bounds(bounds_t b);
    wait_for_codes();
    for (int i = 0; i < 8; i++) write_bound(reg_idx_t'(i), b[(7 - i) * WIDTH_W +: WIDTH_W]);
  endtask

  // Mostly whole frames with random content, the rest noise and broken frames
  task automatic run_mix(int n);
    int stop;
    int r;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_frame(34, $urandom_range(0, 9) == 0);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 6)) send_interval(16'($urandom), 1'($urandom));
      end else if (r < 92) begin
        send_frame($urandom_range(2, 33), 1'b0);
        send_interval(abort_width(), 1'($urandom));
      end else begin
        // a start-sized interval with the line high
        send_interval(start_width(), 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a counted hold-off when asked
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!idle_enable) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0 && free_run == 0) begin
        stall_run = idle_length();
        free_run  = $urandom_range(1, 12);
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        free_run--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    if (fail_count < 40)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_codes
    code_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("result transaction with none expected", out_code_word, 0);
      end else begin
        want = expected_codes.pop_front();
        if (out_code_valid !== want.code_valid)
          report_mismatch("code_valid", out_code_valid, want.code_valid);
        if (out_code_word !== want.code_word)
          report_mismatch("code_word", out_code_word, want.code_word);
        if (out_falling_only !== want.falling_only)
          report_mismatch("falling_only", out_falling_only, want.falling_only);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, start window edges, every width class and the abort paths
  task automatic test_directed_edges();
    send_interval(16'd0, 1'b0);
    send_interval(16'hFFFF, 1'b1);
    send_interval(16'hFFFF, 1'b0);
    send_interval(16'd1300, 1'b0);   // window is exclusive
    send_interval(16'd1700, 1'b0);
    send_interval(16'd1500, 1'b1);   // line high: ignored
    send_interval(16'd1301, 1'b0);   // opens a frame
    send_interval(16'd2200, 1'b0);
    send_interval(16'd1800, 1'b1);
    send_interval(16'd2800, 1'b0);   // three after 1
    send_interval(16'd3800, 1'b1);   // four after 0
    send_interval(16'd4200, 1'b0);
    send_interval(16'd3200, 1'b1);   // three after 0
    send_interval(16'd4000, 1'b0);   // four after 1 aborts
    send_interval(16'd1699, 1'b0);
    send_interval(16'd1799, 1'b0);
    send_interval(16'd1301, 1'b0);
    send_interval(16'd2201, 1'b0);
    send_interval(16'd1500, 1'b0);
    send_interval(16'd4201, 1'b1);
    send_interval(16'd1500, 1'b0);
    send_interval(16'd0, 1'b0);
    send_interval(16'd1500, 1'b0);
    send_interval(16'hFFFF, 1'b1);
  endtask

  task automatic test_clean_frames();
    repeat (6) send_frame(34, 1'b0);
  endtask

  // Frame reaches its last bit on the step that aborts it
  task automatic test_final_bit_abort();
    repeat (8) begin
      send_frame(33, 1'b0);
      if (frame_open && bits_seen == 7'd33) begin
        if (shift_bits[0] && $urandom_range(0, 1) == 0)
          send_interval(unit_width(UNITS_FOUR), 1'($urandom));
        else
          send_interval(abort_width(), 1'($urandom));
      end
    end
  endtask

  // Count jumps over the frame length, frame runs on until an abort
  task automatic test_count_skip();
    repeat (5) begin
      send_frame(33, 1'b0);
      if (frame_open && bits_seen == 7'd33) begin
        send_interval(unit_width(shift_bits[0] ? UNITS_THREE : UNITS_FOUR), 1'($urandom));
        continue_frame(int'(bits_seen) + $urandom_range(1, 10), 1'b1);
      end
      send_interval(abort_width(), 1'($urandom));
    end
  endtask

  // Bit counter pinned at its top value
  task automatic test_count_saturation();
    repeat (2) begin
      send_frame(33, 1'b0);
      if (frame_open && bits_seen == 7'd33) begin
        send_interval(unit_width(shift_bits[0] ? UNITS_THREE : UNITS_FOUR), 1'($urandom));
        continue_frame(int'(COUNT_MAX), 1'b1);
        repeat (4) begin
          if (frame_open) send_interval(unit_width(pick_class(1'b1, int'(COUNT_MAX))), 1'b0);
        end
      end
      send_interval(abort_width(), 1'($urandom));
    end
  endtask

  // Receiver holds off while the sender keeps offering; then a full drain pause
  task automatic test_backpressure();
    wait_for_codes();
    idle_enable = 1'b0;
    hold_left   = 150;
    send_frame(34, 1'b0);
    send_frame(34, 1'b0);
    idle_enable = 1'b1;
    wait_for_codes();
    run_mix(40);
  endtask

  task automatic test_no_idle();
    idle_enable = 1'b0;
    run_mix(100);
    idle_enable = 1'b1;
  endtask

  // Several bound settings, including both ends of every register
  task automatic test_bound_settings();
    bounds_t b;
    repeat (3) begin
      apply_bounds(scaled_bounds($urandom_range(10, 15000)));
      run_mix(40);
    end
    // overlapping classes: two wins over three, three over four
    b = scaled_bounds(1000);
    b.two_max   = 16'd3000;
    b.three_min = 16'd2000;
    b.four_min  = 16'd3000;
    apply_bounds(b);
    run_mix(40);
    // empty classes
    b = scaled_bounds(500);
    b.three_min = b.three_max + 1'b1;
    b.four_min  = 16'hFFFF;
    b.four_max  = 16'd0;
    apply_bounds(b);
    run_mix(30);
    // all zero: no start possible
    apply_bounds('0);
    run_mix(20);
    // widest start window, every width counts as two units
    b.start_min = 16'd0;
    b.start_max = 16'hFFFF;
    b.two_min   = 16'd0;
    b.two_max   = 16'hFFFF;
    b.three_min = 16'hFFFF;
    b.three_max = 16'hFFFF;
    b.four_min  = 16'hFFFF;
    b.four_max  = 16'hFFFF;
    apply_bounds(b);
    run_mix(40);
    // all ones
    apply_bounds('1);
    run_mix(20);
    apply_bounds(default_bounds());
  endtask

  task automatic test_random_traffic();
    if (items_sent < MIX_TARGET) run_mix(MIX_TARGET - items_sent);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    bounds_now = default_bounds();
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_clean_frames();
    test_final_bit_abort();
    test_count_skip();
    test_count_saturation();
    test_backpressure();
    test_no_idle();
    test_bound_settings();
    test_random_traffic();

    wait_for_codes();
    repeat (CODE_LATENCY * 4) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pwbd_pkg.sv
rtl/core/pwbd_regs.sv
rtl/core/pwbd_front.sv
rtl/core/pwbd_queue.sv
rtl/core/pwbd_back.sv
rtl/core/pulse_width_biphase_decoder.sv
tb/sv/pulse_width_biphase_decoder_test.sv
